// ===== hw/rtl/pump_pressure_controller_unit_defines.svh =====
// assertion macros for the pump pressure controller
// used by pump_pressure_controller_unit; expects i_clk and i_rst_n in scope
`ifndef PUMP_PRESSURE_CONTROLLER_UNIT_DEFINES_SVH
`define PUMP_PRESSURE_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ppc_pkg.sv =====
// constants, register indexes and the pulse to flow conversion
// for the pump pressure controller; no dependencies
package ppc_pkg;

    localparam int PRESSURE_W = 14;
    localparam int PULSES_W   = 12;
    localparam int FLOW_W     = 15;
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // operating modes
    localparam logic [1:0] MODE_PRIME      = 2'd0;
    localparam logic [1:0] MODE_RUN        = 2'd1;
    localparam logic [1:0] MODE_PRIME_FAIL = 2'd2;
    localparam logic [1:0] MODE_DRY_FAULT  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_PRESSURE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_PRESSURE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_PRESSURE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_FLOW_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_FLOW_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY_DELAY_MS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_TIMEOUT_MS = 3'd6;

    // register reset values
    localparam logic [PRESSURE_W-1:0] RST_START_PRESSURE   = 14'd1400;
    localparam logic [PRESSURE_W-1:0] RST_STOP_PRESSURE    = 14'd3000;
    localparam logic [PRESSURE_W-1:0] RST_DRY_PRESSURE     = 14'd2400;
    localparam logic [FLOW_W-1:0]     RST_DRY_FLOW_LIMIT   = 15'd20;
    localparam logic [FLOW_W-1:0]     RST_CLEAR_FLOW_LIMIT = 15'd30;
    localparam logic [DELAY_W-1:0]    RST_DRY_DELAY_MS     = 16'd4000;
    localparam logic [DELAY_W-1:0]    RST_PRIME_TIMEOUT_MS = 16'd15000;

    // readings this soon after priming starts are ignored
    localparam logic [TIME_W-1:0] IGNORE_MS = 32'd1000;

    // pulses*60/11 as one multiply by 60*ceil(2^22/11) and a shift by 22;
    // exact for every 12-bit pulse count
    localparam int FLOW_SHIFT = 22;
    localparam int FLOW_RECIP = (2**FLOW_SHIFT + 10) / 11;
    localparam int FLOW_PROD_W = PULSES_W + 25;
    localparam logic [FLOW_PROD_W-1:0] FLOW_SCALE = FLOW_PROD_W'(60 * FLOW_RECIP);

    function automatic logic [FLOW_W-1:0] to_lph(input logic [PULSES_W-1:0] pulses);
        logic [FLOW_PROD_W-1:0] prod;
        prod = {{(FLOW_PROD_W-PULSES_W){1'b0}}, pulses} * FLOW_SCALE;
        return prod[FLOW_SHIFT +: FLOW_W];
    endfunction

endpackage

// ===== hw/rtl/pump_pressure_controller_unit.sv =====
// pump pressure controller: priming, hysteresis pump control and dry-run fault
// depends on ppc_pkg and pump_pressure_controller_unit_defines.svh
`include "pump_pressure_controller_unit_defines.svh"

// Takes one measurement per clock, unless stalled, and returns one result per
// measurement. A request passes through two registers: the input register,
// where the pulse counts are converted to liters per hour, and the result
// register, which the control step loads while it updates the pump state.
// o_valid rises when the control step loads the result register; sustained
// rate is one request per cycle while the result side does not stall, set by
// the single control stage that reads and writes the state.
// o_stall rises only when the input register is full and the result
// register is full and stalled downstream. Registers written through the
// configuration port apply to the next request that reaches the control stage.
module pump_pressure_controller_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // measurement request
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [ppc_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [ppc_pkg::PRESSURE_W-1:0]   i_pressure,
    input  logic [ppc_pkg::PULSES_W-1:0]     i_pulses,
    input  logic [ppc_pkg::PRESSURE_W-1:0]   i_confirm_pressure,
    input  logic [ppc_pkg::PULSES_W-1:0]     i_confirm_pulses,
    // result request
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_pump_on,
    output logic [1:0]                       o_mode,
    output logic [ppc_pkg::FLOW_W-1:0]       o_flow_lph,
    output logic                             o_dry_warning
);
    import ppc_pkg::*;

    // configuration registers
    logic [PRESSURE_W-1:0] r_start_pressure;
    logic [PRESSURE_W-1:0] r_stop_pressure;
    logic [PRESSURE_W-1:0] r_dry_pressure;
    logic [FLOW_W-1:0]     r_dry_flow_limit;
    logic [FLOW_W-1:0]     r_clear_flow_limit;
    logic [DELAY_W-1:0]    r_dry_delay_ms;
    logic [DELAY_W-1:0]    r_prime_timeout_ms;

    // input register
    logic                  r_in_valid;
    logic [TIME_W-1:0]     r_now;
    logic [PRESSURE_W-1:0] r_p;
    logic [FLOW_W-1:0]     r_flow;
    logic [PRESSURE_W-1:0] r_cp;
    logic [FLOW_W-1:0]     r_cflow;

    // controller state
    logic [1:0]            r_mode;
    logic                  r_pump;
    logic                  r_armed;
    logic [TIME_W-1:0]     r_warn_start;
    logic [TIME_W-1:0]     r_prime_start;
    logic                  r_prime_started;

    logic [1:0]            n_mode;
    logic                  n_pump;
    logic                  n_armed;
    logic [TIME_W-1:0]     n_warn_start;
    logic [TIME_W-1:0]     n_prime_start;
    logic                  n_prime_started;
    logic [FLOW_W-1:0]     n_flow;

    // result register
    logic                  r_out_valid;
    logic                  r_out_pump;
    logic [1:0]            r_out_mode;
    logic [FLOW_W-1:0]     r_out_flow;
    logic                  r_out_warn;

    logic                  in_take;
    logic                  step;

    assign step    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !step;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pressure   <= RST_START_PRESSURE;
            r_stop_pressure    <= RST_STOP_PRESSURE;
            r_dry_pressure     <= RST_DRY_PRESSURE;
            r_dry_flow_limit   <= RST_DRY_FLOW_LIMIT;
            r_clear_flow_limit <= RST_CLEAR_FLOW_LIMIT;
            r_dry_delay_ms     <= RST_DRY_DELAY_MS;
            r_prime_timeout_ms <= RST_PRIME_TIMEOUT_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_PRESSURE:   r_start_pressure   <= i_cfg_data[PRESSURE_W-1:0];
                CFG_STOP_PRESSURE:    r_stop_pressure    <= i_cfg_data[PRESSURE_W-1:0];
                CFG_DRY_PRESSURE:     r_dry_pressure     <= i_cfg_data[PRESSURE_W-1:0];
                CFG_DRY_FLOW_LIMIT:   r_dry_flow_limit   <= i_cfg_data[FLOW_W-1:0];
                CFG_CLEAR_FLOW_LIMIT: r_clear_flow_limit <= i_cfg_data[FLOW_W-1:0];
                CFG_DRY_DELAY_MS:     r_dry_delay_ms     <= i_cfg_data[DELAY_W-1:0];
                CFG_PRIME_TIMEOUT_MS: r_prime_timeout_ms <= i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // input register, flow conversion on the way in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now   <= i_now_ms;
            r_p     <= i_pressure;
            r_flow  <= to_lph(i_pulses);
            r_cp    <= i_confirm_pressure;
            r_cflow <= to_lph(i_confirm_pulses);
        end
    end

    // control step
    always_comb begin
        logic [PRESSURE_W-1:0] v_p;
        logic [TIME_W-1:0]     prime_el;
        logic [TIME_W-1:0]     warn_el;
        n_mode          = r_mode;
        n_pump          = r_pump;
        n_armed         = r_armed;
        n_warn_start    = r_warn_start;
        n_prime_start   = r_prime_start;
        n_prime_started = r_prime_started;
        n_flow          = r_flow;
        v_p             = r_p;
        prime_el        = '0;
        warn_el         = '0;
        case (r_mode)
            MODE_PRIME: begin
                if (!r_prime_started) begin
                    n_prime_start   = r_now;
                    n_prime_started = 1'b1;
                end
                prime_el = r_now - n_prime_start;
                if (prime_el >= IGNORE_MS) begin
                    if (prime_el < {{(TIME_W-DELAY_W){1'b0}}, r_prime_timeout_ms}) begin
                        if (v_p >= r_stop_pressure) begin
                            n_pump = 1'b0;
                            n_mode = MODE_RUN;
                        end
                    end else begin
                        n_pump = 1'b0;
                        n_mode = MODE_PRIME_FAIL;
                    end
                end
            end
            MODE_RUN: begin
                // start needs the confirming reading too
                if (v_p <= r_start_pressure && !n_pump) begin
                    n_flow = r_cflow;
                    v_p    = r_cp;
                    if (v_p <= r_start_pressure) begin
                        n_pump = 1'b1;
                    end
                end
                // stop needs the confirming reading too, with zero flow
                if (v_p >= r_stop_pressure && n_flow == '0 && n_pump) begin
                    n_flow = r_cflow;
                    v_p    = r_cp;
                    if (v_p >= r_stop_pressure && n_flow == '0) begin
                        n_pump = 1'b0;
                    end
                end
                if (n_pump && !n_armed && v_p < r_dry_pressure && n_flow < r_dry_flow_limit) begin
                    n_armed      = 1'b1;
                    n_warn_start = r_now;
                end
                warn_el = r_now - n_warn_start;
                if (n_armed && warn_el >= {{(TIME_W-DELAY_W){1'b0}}, r_dry_delay_ms}) begin
                    n_pump  = 1'b0;
                    n_armed = 1'b0;
                    n_mode  = MODE_DRY_FAULT;
                end else if (v_p >= r_stop_pressure || n_flow > r_clear_flow_limit) begin
                    n_armed = 1'b0;
                end
            end
            default: ;
        endcase
        if (n_mode == MODE_PRIME_FAIL || n_mode == MODE_DRY_FAULT) begin
            n_pump  = 1'b0;
            n_armed = 1'b0;
            n_flow  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_PRIME;
            r_pump          <= 1'b1;
            r_armed         <= 1'b0;
            r_warn_start    <= '0;
            r_prime_start   <= '0;
            r_prime_started <= 1'b0;
        end else if (step) begin
            r_mode          <= n_mode;
            r_pump          <= n_pump;
            r_armed         <= n_armed;
            r_warn_start    <= n_warn_start;
            r_prime_start   <= n_prime_start;
            r_prime_started <= n_prime_started;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_pump <= n_pump;
            r_out_mode <= n_mode;
            r_out_flow <= n_flow;
            r_out_warn <= n_armed;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pump_on     = r_out_pump;
    assign o_mode        = r_out_mode;
    assign o_flow_lph    = r_out_flow;
    assign o_dry_warning = r_out_warn;

    `PPC_ASSERT_NOW(a_fault_outputs_quiet,
        o_valid && (o_mode == MODE_PRIME_FAIL || o_mode == MODE_DRY_FAULT),
        !o_pump_on && !o_dry_warning && o_flow_lph == '0,
        "fault result with pump, flow or warning set")
    `PPC_ASSERT_NEXT(a_fault_latched,
        r_mode == MODE_PRIME_FAIL || r_mode == MODE_DRY_FAULT,
        r_mode == $past(r_mode),
        "latched fault mode changed")
    `PPC_ASSERT_NOW(a_warning_only_running,
        o_valid && o_dry_warning,
        o_mode == MODE_RUN && o_pump_on,
        "dry warning outside running control or with pump off")
    `PPC_ASSERT_NOW(a_stall_when_full,
        o_stall,
        r_in_valid && r_out_valid && i_stall,
        "input stalled while the pipeline can move")

endmodule

// ===== dv/pump_pressure_checker.sv =====
// result checker for pump_pressure_controller_unit: follows the register and
// measurement traffic, predicts every result and compares it field by field
// depends on ppc_pkg for port widths and mode codes
module pump_pressure_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_meas_valid,
    input  logic                           i_meas_stall,
    input  logic [ppc_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [ppc_pkg::PRESSURE_W-1:0] i_pressure,
    input  logic [ppc_pkg::PULSES_W-1:0]   i_pulses,
    input  logic [ppc_pkg::PRESSURE_W-1:0] i_confirm_pressure,
    input  logic [ppc_pkg::PULSES_W-1:0]   i_confirm_pulses,
    input  logic                           i_res_valid,
    input  logic                           i_res_stall,
    input  logic                           i_pump_on,
    input  logic [1:0]                     i_mode,
    input  logic [ppc_pkg::FLOW_W-1:0]     i_flow_lph,
    input  logic                           i_dry_warning,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppc_pkg::*;

    localparam logic [31:0] PRIME_BLANK_MS = 32'd1000;

    typedef struct packed {
        logic              pump_on;
        logic [1:0]        mode;
        logic [FLOW_W-1:0] flow_lph;
        logic              dry_warning;
    } t_pump_result;

    // register copies
    logic [13:0] start_p, stop_p, dry_p;
    logic [14:0] dry_flow_lim, clear_flow_lim;
    logic [15:0] dry_delay, prime_timeout;

    // controller state
    logic [1:0]  mode_q;
    logic        pump_q;
    logic        warn_q;
    logic [31:0] warn_start_q;
    logic [31:0] prime_start_q;
    logic        prime_started_q;

    t_pump_result expected_q[$];
    t_pump_result want;

    function automatic logic [14:0] pulses_to_lph(input logic [11:0] n);
        logic [31:0] prod;
        prod = 32'(n) * 32'd60;
        return 15'(prod / 32'd11);
    endfunction

    function automatic t_pump_result predict_control(
        input logic [31:0] now,
        input logic [13:0] p_first,
        input logic [11:0] pl_first,
        input logic [13:0] cp,
        input logic [11:0] cpl
    );
        t_pump_result r;
        logic [13:0]  p;
        logic [14:0]  flow;
        logic [14:0]  cflow;
        logic [31:0]  elapsed;
        p = p_first;
        flow = pulses_to_lph(pl_first);
        cflow = pulses_to_lph(cpl);
        case (mode_q)
            MODE_PRIME: begin
                if (!prime_started_q) begin
                    prime_start_q = now;
                    prime_started_q = 1'b1;
                end
                elapsed = now - prime_start_q;
                if (elapsed >= PRIME_BLANK_MS) begin
                    if (elapsed < {16'd0, prime_timeout}) begin
                        if (p >= stop_p) begin
                            pump_q = 1'b0;
                            mode_q = MODE_RUN;
                        end
                    end else begin
                        pump_q = 1'b0;
                        mode_q = MODE_PRIME_FAIL;
                    end
                end
            end
            MODE_RUN: begin
                // a taken confirmation replaces the first reading from here on
                if (p <= start_p && !pump_q) begin
                    flow = cflow;
                    p = cp;
                    if (p <= start_p) pump_q = 1'b1;
                end
                if (p >= stop_p && flow == '0 && pump_q) begin
                    flow = cflow;
                    p = cp;
                    if (p >= stop_p && flow == '0) pump_q = 1'b0;
                end
                if (pump_q && !warn_q && p < dry_p && flow < dry_flow_lim) begin
                    warn_q = 1'b1;
                    warn_start_q = now;
                end
                if (warn_q && (now - warn_start_q) >= {16'd0, dry_delay}) begin
                    pump_q = 1'b0;
                    warn_q = 1'b0;
                    mode_q = MODE_DRY_FAULT;
                end else if (p >= stop_p || flow > clear_flow_lim) begin
                    warn_q = 1'b0;
                end
            end
            default: begin
            end
        endcase
        if (mode_q == MODE_PRIME_FAIL || mode_q == MODE_DRY_FAULT) begin
            pump_q = 1'b0;
            warn_q = 1'b0;
            flow = '0;
        end
        r.pump_on = pump_q;
        r.mode = mode_q;
        r.flow_lph = flow;
        r.dry_warning = warn_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_p = 14'd1400;
            stop_p = 14'd3000;
            dry_p = 14'd2400;
            dry_flow_lim = 15'd20;
            clear_flow_lim = 15'd30;
            dry_delay = 16'd4000;
            prime_timeout = 16'd15000;
            mode_q = MODE_PRIME;
            pump_q = 1'b1;
            warn_q = 1'b0;
            warn_start_q = '0;
            prime_start_q = '0;
            prime_started_q = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_PRESSURE:   start_p = i_cfg_data[13:0];
                    CFG_STOP_PRESSURE:    stop_p = i_cfg_data[13:0];
                    CFG_DRY_PRESSURE:     dry_p = i_cfg_data[13:0];
                    CFG_DRY_FLOW_LIMIT:   dry_flow_lim = i_cfg_data[14:0];
                    CFG_CLEAR_FLOW_LIMIT: clear_flow_lim = i_cfg_data[14:0];
                    CFG_DRY_DELAY_MS:     dry_delay = i_cfg_data;
                    CFG_PRIME_TIMEOUT_MS: prime_timeout = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // a result can never belong to a request taken at the same edge
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result request with no measurement waiting");
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    o_checked++;
                    if (i_pump_on !== want.pump_on) begin
                        $error("pump_on: expected %0d, got %0d", want.pump_on, i_pump_on);
                        o_errors++;
                    end
                    if (i_mode !== want.mode) begin
                        $error("mode: expected %0d, got %0d", want.mode, i_mode);
                        o_errors++;
                    end
                    if (i_flow_lph !== want.flow_lph) begin
                        $error("flow_lph: expected %0d, got %0d", want.flow_lph, i_flow_lph);
                        o_errors++;
                    end
                    if (i_dry_warning !== want.dry_warning) begin
                        $error("dry_warning: expected %0d, got %0d",
                               want.dry_warning, i_dry_warning);
                        o_errors++;
                    end
                end
            end
            if (i_meas_valid && !i_meas_stall) begin
                expected_q.push_back(predict_control(i_now_ms, i_pressure, i_pulses,
                                                     i_confirm_pressure, i_confirm_pulses));
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// top of the pump pressure controller testbench: clock, reset, register
// settings and measurement traffic; the checker beside the block does the
// predicting; depends on ppc_pkg, pump_pressure_checker and the block
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    localparam int P_MAX = 16383;
    localparam int F_MAX = 32767;
    localparam int D_MAX = 65535;
    localparam int PHASE_ITEMS = 75;
    localparam int RANDOM_PHASES = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [TIME_W-1:0]     i_now_ms;
    logic [PRESSURE_W-1:0] i_pressure;
    logic [PULSES_W-1:0]   i_pulses;
    logic [PRESSURE_W-1:0] i_confirm_pressure;
    logic [PULSES_W-1:0]   i_confirm_pulses;
    logic                  o_valid;
    logic                  i_stall;
    logic                  o_pump_on;
    logic [1:0]            o_mode;
    logic [FLOW_W-1:0]     o_flow_lph;
    logic                  o_dry_warning;

    int errors;
    int pending;
    int checked;

    // stimulus state
    logic [31:0] t_ms;
    int since_clear;
    int burst_left;
    int sent;
    int settings_used;
    int cfg_start, cfg_stop, cfg_dry_p, cfg_dry_flow, cfg_clear_flow;
    int cfg_delay, cfg_prime;

    pump_pressure_controller_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_now_ms           (i_now_ms),
        .i_pressure         (i_pressure),
        .i_pulses           (i_pulses),
        .i_confirm_pressure (i_confirm_pressure),
        .i_confirm_pulses   (i_confirm_pulses),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_pump_on          (o_pump_on),
        .o_mode             (o_mode),
        .o_flow_lph         (o_flow_lph),
        .o_dry_warning      (o_dry_warning)
    );

    pump_pressure_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_meas_valid       (i_valid),
        .i_meas_stall       (o_stall),
        .i_now_ms           (i_now_ms),
        .i_pressure         (i_pressure),
        .i_pulses           (i_pulses),
        .i_confirm_pressure (i_confirm_pressure),
        .i_confirm_pulses   (i_confirm_pulses),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_pump_on          (o_pump_on),
        .i_mode             (o_mode),
        .i_flow_lph         (o_flow_lph),
        .i_dry_warning      (o_dry_warning),
        .o_errors           (errors),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $error("run did not finish in time");
        $display("*** FAILED ***");
        $finish;
    end

    // result side stalls in spans: none, light and heavy
    initial begin : result_stall
        int style;
        int span;
        i_stall <= 1'b0;
        forever begin
            style = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                case (style)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    default: i_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic int near(input int center, input int hi);
        int v;
        v = center + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > hi) v = hi;
        return v;
    endfunction

    // now and then push a register value to one of its ends
    function automatic int vary(input int v, input int hi);
        if ($urandom_range(0, 5) != 0) return v;
        return ($urandom_range(0, 1) == 0) ? 0 : hi;
    endfunction

    task automatic send_measurement(input int dt, input int p, input int pl,
                                    input int cp, input int cpl);
        int gap;
        t_ms += 32'(dt);
        since_clear += dt;
        i_valid <= 1'b1;
        i_now_ms <= t_ms;
        i_pressure <= p[13:0];
        i_pulses <= pl[11:0];
        i_confirm_pressure <= cp[13:0];
        i_confirm_pulses <= cpl[11:0];
        do @(posedge i_clk); while (o_stall);
        sent++;
        burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // every result back means the block is idle; each request makes one
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // unused upper data bits are filled at random, the block drops them
    task automatic apply_settings();
        write_reg(CFG_START_PRESSURE, {2'($urandom), 14'(cfg_start)});
        write_reg(CFG_STOP_PRESSURE, {2'($urandom), 14'(cfg_stop)});
        write_reg(CFG_DRY_PRESSURE, {2'($urandom), 14'(cfg_dry_p)});
        write_reg(CFG_DRY_FLOW_LIMIT, {1'($urandom), 15'(cfg_dry_flow)});
        write_reg(CFG_CLEAR_FLOW_LIMIT, {1'($urandom), 15'(cfg_clear_flow)});
        write_reg(CFG_DRY_DELAY_MS, 16'(cfg_delay));
        write_reg(CFG_PRIME_TIMEOUT_MS, 16'(cfg_prime));
        write_reg(CFG_NO_REG, 16'($urandom));
        settings_used++;
    endtask

    initial begin : stimulus
        int ph;
        int i;
        int kind;
        int room;
        int cap;
        int dt;
        int p, pl, cp, cpl;
        int drain;
        bit can_arm;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_now_ms <= '0;
        i_pressure <= '0;
        i_pulses <= '0;
        i_confirm_pressure <= '0;
        i_confirm_pulses <= '0;
        sent = 0;
        settings_used = 1;
        since_clear = 0;
        burst_left = $urandom_range(1, 16);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // priming on reset settings; the timestamp wraps during the blank time
        t_ms = 32'hFFFF_FE00 + 32'($urandom_range(0, 255));
        send_measurement(0, P_MAX, 4095, 0, 0);
        send_measurement(999, P_MAX, 4095, P_MAX, 4095);
        send_measurement(1, 2999, 1, 0, 0);
        send_measurement(13999, 2999, 0, P_MAX, 0);
        send_measurement(0, 3000, 5, 0, 0);
        // run control: confirmations, dry-run warning up to one ms short of fault
        send_measurement(10, 1400, 0, 1401, 7);
        send_measurement(10, 0, 4095, 0, 0);
        send_measurement(3999, 1000, 3, 1000, 0);
        send_measurement(0, 1000, 6, 0, 0);
        send_measurement(10, 3000, 0, 2999, 0);
        send_measurement(10, P_MAX, 0, 3000, 1);
        send_measurement(10, P_MAX, 0, P_MAX, 0);
        wait_idle();

        // start and stop windows overlap so one step can take both tests
        cfg_start = P_MAX;
        cfg_stop = 0;
        cfg_dry_p = 2400;
        cfg_dry_flow = 20;
        cfg_clear_flow = 30;
        cfg_delay = 4000;
        cfg_prime = 15000;
        apply_settings();
        send_measurement(10, 5, 0, 7, 0);
        send_measurement(10, 9, 0, 3, 4095);
        send_measurement(10, P_MAX, 0, P_MAX, 0);
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                cfg_start = P_MAX;
                cfg_stop = P_MAX;
                cfg_dry_p = P_MAX;
                cfg_dry_flow = F_MAX;
                cfg_clear_flow = F_MAX;
                cfg_delay = D_MAX;
                cfg_prime = D_MAX;
            end else if (ph == 1) begin
                cfg_start = 0;
                cfg_stop = 0;
                cfg_dry_p = 0;
                cfg_dry_flow = 0;
                cfg_clear_flow = 0;
                cfg_delay = 0;
                cfg_prime = 0;
            end else begin
                cfg_start = vary($urandom_range(200, 6000), P_MAX);
                cfg_stop = vary($urandom_range(cfg_start, 12000), P_MAX);
                cfg_dry_p = vary($urandom_range(cfg_start, cfg_stop), P_MAX);
                cfg_dry_flow = vary($urandom_range(0, 200), F_MAX);
                cfg_clear_flow = vary($urandom_range(cfg_dry_flow, 400), F_MAX);
                cfg_delay = vary($urandom_range(1, 20000), D_MAX);
                cfg_prime = vary($urandom_range(0, D_MAX), D_MAX);
            end
            can_arm = (cfg_dry_p != 0) && (cfg_dry_flow != 0);
            // a zero delay is only safe where the warning can never arm
            if (can_arm && cfg_delay == 0) cfg_delay = 1;
            apply_settings();
            since_clear = 0;
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // time since the last clearing request stays below the delay,
                // so the warning never runs out here
                room = can_arm ? cfg_delay - 1 - since_clear : 2000;
                cap = can_arm ? cfg_delay / 8 + 1 : 2000;
                if ($urandom_range(0, 9) == 0) dt = room;
                else dt = $urandom_range(0, (room < cap) ? room : cap);
                kind = (i == PHASE_ITEMS - 1) ? 5 : $urandom_range(0, 5);
                case (kind)
                    0: begin
                        p = ($urandom_range(0, 1) == 0) ? $urandom_range(0, cfg_start)
                                                        : near(cfg_start, P_MAX);
                        pl = $urandom_range(0, 4095);
                        cp = near(cfg_start, P_MAX);
                        cpl = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 4095);
                    end
                    1: begin
                        p = ($urandom_range(0, 1) == 0) ? $urandom_range(cfg_stop, P_MAX)
                                                        : near(cfg_stop, P_MAX);
                        pl = ($urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 3);
                        cp = near(cfg_stop, P_MAX);
                        cpl = ($urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 3);
                    end
                    2: begin
                        p = $urandom_range(0, (cfg_dry_p > 0) ? cfg_dry_p - 1 : 0);
                        pl = $urandom_range(0, 4);
                        cp = $urandom_range(0, cfg_dry_p);
                        cpl = $urandom_range(0, 4);
                    end
                    3: begin
                        p = $urandom_range(0, P_MAX);
                        pl = $urandom_range(0, 4095);
                        cp = $urandom_range(0, P_MAX);
                        cpl = $urandom_range(0, 4095);
                    end
                    4: begin
                        // flow right around the arming and clearing limits
                        p = $urandom_range(0, P_MAX);
                        pl = near(cfg_clear_flow * 11 / 60, 4095);
                        cp = $urandom_range(0, P_MAX);
                        cpl = near(cfg_dry_flow * 11 / 60, 4095);
                    end
                    default: begin
                        // full-scale pressure on both readings always clears the warning
                        p = P_MAX;
                        pl = $urandom_range(0, 4095);
                        cp = P_MAX;
                        cpl = $urandom_range(0, 4095);
                    end
                endcase
                send_measurement(dt, p, pl, cp, cpl);
                if (kind == 5) since_clear = 0;
            end
            wait_idle();
        end

        // dry-run timer runs out: exactly at the delay, or at once with zero delay
        cfg_start = P_MAX;
        cfg_stop = P_MAX;
        cfg_dry_p = P_MAX;
        cfg_dry_flow = F_MAX;
        cfg_clear_flow = F_MAX;
        cfg_delay = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, D_MAX);
        cfg_prime = $urandom_range(0, D_MAX);
        apply_settings();
        send_measurement(10, 0, 0, 0, 0);
        if (cfg_delay > 0) begin
            send_measurement(cfg_delay - 1, 100, 2, 200, 2);
            send_measurement(1, 100, 2, 200, 2);
        end
        // the fault is latched; these must all come back as fault results
        repeat (5) begin
            send_measurement($urandom_range(0, 5000), $urandom_range(0, P_MAX),
                             $urandom_range(0, 4095), $urandom_range(0, P_MAX),
                             $urandom_range(0, 4095));
        end
        i_valid <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 2000) begin
            @(negedge i_clk);
            drain++;
        end
        // late extra results would still show up as unexpected
        repeat (10) @(posedge i_clk);
        if (pending != 0) $error("%0d results never came back", pending);

        $display("%0d measurement requests under %0d register settings, %0d results compared",
                 sent, settings_used, checked);
        $display("covered: priming with blank time, run control, dry-run warning and fault");
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
